@@ rtl/tlru_pkg.sv @@
// shared types and constants for the two-tier lru cache core
// no dependencies; imported by every module in rtl/

package tlru_pkg;

  localparam int WAYS     = 16;
  localparam int KEY_BITS = 64;
  localparam int DATA_BITS = 64;
  localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W    = $clog2(WAYS + 1);
  localparam int CFG_W    = 5;
  localparam int OCC_W    = 5;

  localparam logic [0:0] REG_PRIMARY_CAP = 1'b0;
  localparam logic [0:0] REG_PRELOAD_CAP = 1'b1;

  localparam logic OP_PUT = 1'b0;
  localparam logic OP_GET = 1'b1;

  localparam logic TIER_PRIMARY = 1'b0;
  localparam logic TIER_PRELOAD = 1'b1;

  localparam logic [1:0] REQ_NONE = 2'd0;
  localparam logic [1:0] REQ_PUT  = 2'd1;
  localparam logic [1:0] REQ_GET  = 2'd2;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

  typedef struct packed {
    logic                 op;
    logic                 tier;
    logic [63:0]          key;
    logic [63:0]          payload;
  } in_t;

  typedef struct packed {
    logic                 hit;
    logic                 hit_tier;
    logic [63:0]          data_out;
    logic [OCC_W-1:0]     primary_count;
    logic [OCC_W-1:0]     preload_count;
  } out_t;

  typedef struct packed {
    logic                 apply;
    logic                 touch_en;
    logic                 write_en;
    logic [RANK_W-1:0]    touch_rank;
    logic                 insert_en;
    logic                 evict_en;
    logic [RANK_W-1:0]    evict_rank;
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] data;
  } cell_ctl_t;

  typedef struct packed {
    logic                 free_seen;
    logic                 hit;
    logic [RANK_W-1:0]    hit_rank;
    logic [DATA_BITS-1:0] hit_data;
  } chain_t;

endpackage

@@ rtl/tlru_cell.sv @@
// one cache entry: key, data, recency rank and valid bit
// depends on tlru_pkg; chained by tlru_tier

module tlru_cell import tlru_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  chain_t    chain_in,
  output chain_t    chain_out,
  output logic      held,
  output logic      match
);

  logic                 valid;
  logic [KEY_BITS-1:0]  key;
  logic [DATA_BITS-1:0] data;
  logic [RANK_W-1:0]    rank;
  logic                 is_evict;
  logic                 free;
  logic                 slot;

  assign held     = valid;
  assign match    = valid && (key == ctl.key);
  assign is_evict = ctl.evict_en && valid && (rank == ctl.evict_rank);
  assign free     = !valid || is_evict;
  assign slot     = free && !chain_in.free_seen;

  assign chain_out.free_seen = chain_in.free_seen | free;
  assign chain_out.hit       = chain_in.hit | match;
  assign chain_out.hit_rank  = chain_in.hit_rank | (match ? rank : '0);
  assign chain_out.hit_data  = chain_in.hit_data | (match ? data : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.apply && ctl.insert_en) begin
      if (slot) begin
        valid <= 1'b1;
      end else if (is_evict) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.apply) begin
      if (ctl.touch_en) begin
        if (match) begin
          rank <= '0;
          if (ctl.write_en) begin
            data <= ctl.data;
          end
        end else if (valid && (rank < ctl.touch_rank)) begin
          rank <= rank + RANK_W'(1);
        end
      end
      if (ctl.insert_en) begin
        if (slot) begin
          key  <= ctl.key;
          data <= ctl.data;
          rank <= '0;
        end else if (valid && !is_evict) begin
          rank <= rank + RANK_W'(1);
        end
      end
    end
  end

endmodule

@@ rtl/tlru_tier.sv @@
// one tier: a row of cells linked by a free/hit chain plus the occupancy count
// depends on tlru_pkg and tlru_cell

module tlru_tier import tlru_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 apply,
  input  logic [1:0]           req,
  input  logic [CFG_W-1:0]     cap,
  input  logic [KEY_BITS-1:0]  key,
  input  logic [DATA_BITS-1:0] data,
  output logic                 hit,
  output logic [DATA_BITS-1:0] hit_data,
  output logic [CNT_W-1:0]     count_next
);

  chain_t             chain [WAYS+1];
  cell_ctl_t          ctl;
  logic [WAYS-1:0]    held_vec;
  logic [WAYS-1:0]    match_vec;
  logic [CNT_W-1:0]   occ;
  logic [CNT_W-1:0]   occ_dec;
  logic [CNT_W-1:0]   cap_eff;
  logic               over;

  assign chain[0] = '0;

  for (genvar i = 0; i < WAYS; i++) begin : g_cell
    tlru_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .held      (held_vec[i]),
      .match     (match_vec[i])
    );
  end

  assign hit      = chain[WAYS].hit;
  assign hit_data = chain[WAYS].hit_data;
  assign cap_eff  = CNT_W'((32'(cap) > 32'(WAYS)) ? 32'(WAYS) : 32'(cap));
  assign occ_dec  = occ - CNT_W'(1);
  assign over     = ({1'b0, occ} + (CNT_W+1)'(1)) > {1'b0, cap_eff};

  always_comb begin
    ctl            = '0;
    ctl.apply      = apply;
    ctl.key        = key;
    ctl.data       = data;
    ctl.touch_rank = chain[WAYS].hit_rank;
    ctl.evict_rank = occ_dec[RANK_W-1:0];
    case (req)
      REQ_PUT: begin
        if (cap_eff != '0) begin
          if (hit) begin
            ctl.touch_en = 1'b1;
            ctl.write_en = 1'b1;
          end else begin
            ctl.insert_en = 1'b1;
            ctl.evict_en  = over;
          end
        end
      end
      REQ_GET: begin
        ctl.touch_en = hit;
      end
      default: begin
      end
    endcase
  end

  assign count_next = (ctl.insert_en && !over) ? occ + CNT_W'(1) : occ;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (apply) begin
      occ <= count_next;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    32'(occ) <= WAYS)
    else $error("tier occupancy above way count");

  a_occ_tracks_valid: assert property (@(posedge clk) disable iff (rst)
    32'($countones(held_vec)) == 32'(occ))
    else $error("tier occupancy differs from valid cells");

  a_unique_key: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match_vec))
    else $error("key held in more than one cell");

endmodule

@@ rtl/two_tier_lru_cache_core.sv @@
// Two-tier fully associative LRU cache core.
// Input channel in_valid/in_ready carries one word: op (put/get), tier, key,
// payload. Output channel out_valid/out_ready returns one word per input:
// hit, hit_tier, data_out and both tier occupancy counts after the word.
// Config port: cfg_we with cfg_index selects primary (0) or preload (1)
// capacity, written from cfg_data in the same cycle; both reset to 16.
// A word is taken into the command register; in the compare state every cell
// compares the key and, once the output register is free, the whole row
// updates its ranks and contents, loading the output register. One word is
// in flight at a time.
// in_ready is high again as soon as the result is loaded, so the
// next word is taken while the result waits. If the receiver stalls with a
// result pending, the following word holds in the compare cycle until the
// output register frees.
// Reset (synchronous, active high) empties both tiers, clears the counts and
// drops any pending word.
// depends on tlru_pkg, tlru_tier, tlru_cell

module two_tier_lru_cache_core import tlru_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_word,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_word,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  logic                 state;
  in_t                  cmd;
  logic [CFG_W-1:0]     primary_cap;
  logic [CFG_W-1:0]     preload_cap;
  logic                 apply;
  logic [1:0]           req0;
  logic [1:0]           req1;
  logic                 hit0;
  logic                 hit1;
  logic [DATA_BITS-1:0] data0;
  logic [DATA_BITS-1:0] data1;
  logic [CNT_W-1:0]     count0;
  logic [CNT_W-1:0]     count1;
  out_t                 result;

  assign in_ready = (state == ST_IDLE);
  assign apply    = (state == ST_LOOK) && (!out_valid || out_ready);

  always_comb begin
    req0 = REQ_NONE;
    req1 = REQ_NONE;
    if (cmd.op == OP_GET) begin
      req0 = REQ_GET;
      req1 = hit0 ? REQ_NONE : REQ_GET;
    end else if (cmd.tier == TIER_PRIMARY) begin
      req0 = REQ_PUT;
    end else begin
      req1 = REQ_PUT;
    end
  end

  tlru_tier u_primary (
    .clk        (clk),
    .rst        (rst),
    .apply      (apply),
    .req        (req0),
    .cap        (primary_cap),
    .key        (cmd.key[KEY_BITS-1:0]),
    .data       (cmd.payload[DATA_BITS-1:0]),
    .hit        (hit0),
    .hit_data   (data0),
    .count_next (count0)
  );

  tlru_tier u_preload (
    .clk        (clk),
    .rst        (rst),
    .apply      (apply),
    .req        (req1),
    .cap        (preload_cap),
    .key        (cmd.key[KEY_BITS-1:0]),
    .data       (cmd.payload[DATA_BITS-1:0]),
    .hit        (hit1),
    .hit_data   (data1),
    .count_next (count1)
  );

  always_comb begin
    result               = '0;
    result.primary_count = OCC_W'(count0);
    result.preload_count = OCC_W'(count1);
    if (cmd.op == OP_GET) begin
      if (hit0) begin
        result.hit      = 1'b1;
        result.hit_tier = TIER_PRIMARY;
        result.data_out = 64'(data0);
      end else if (hit1) begin
        result.hit      = 1'b1;
        result.hit_tier = TIER_PRELOAD;
        result.data_out = 64'(data1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      primary_cap <= CAP_RESET;
      preload_cap <= CAP_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PRIMARY_CAP: primary_cap <= cfg_data;
          REG_PRELOAD_CAP: preload_cap <= cfg_data;
          default: begin
          end
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_LOOK;
          end
          if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        ST_LOOK: begin
          if (apply) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd <= in_word;
    end
    if (apply) begin
      out_word <= result;
    end
  end

endmodule
